@@ hw/rtl/bipr_pkg.sv @@
// bipr_pkg: shared types and constants for the isolated pixel removal block
package bipr_pkg;

  localparam int ROW_W      = 64;
  localparam int NUM_W      = 12;
  localparam int WIDTH_W    = 7;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int HEIGHT_CAP = 4096;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 7'd64;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd2;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [NUM_W-1:0] num;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       a;
    res_t       b;
  } push_t;

endpackage

@@ hw/rtl/bipr_filter.sv @@
// bipr_filter: 3x3 isolated pixel test for one row against its neighbours
module bipr_filter #(
  parameter int N = 64
) (
  input  logic [N-1:0] above,
  input  logic [N-1:0] mid,
  input  logic [N-1:0] below,
  input  logic [N-1:0] mask,
  output logic [N-1:0] filt
);

  logic [N-1:0] a;
  logic [N-1:0] m;
  logic [N-1:0] b;
  logic [N-1:0] nb;

  assign a  = above & mask;
  assign m  = mid & mask;
  assign b  = below & mask;
  assign nb = a | (a << 1) | (a >> 1) | b | (b << 1) | (b >> 1) | (m << 1) | (m >> 1);
  assign filt = m & nb & mask;

endmodule

@@ hw/rtl/bipr_core.sv @@
// bipr_core: input register, row history, row counter and result generation
module bipr_core #(
  parameter int ROW_PIXELS = 64,
  parameter int MAX_ROWS   = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [bipr_pkg::ROW_W-1:0]          in_row_pixels,
  output logic                                in_stall,
  input  logic [bipr_pkg::WIDTH_W-1:0]        image_width,
  input  logic [bipr_pkg::HEIGHT_W-1:0]       image_height,
  input  logic [1:0]                          free,
  output bipr_pkg::push_t                     push
);
  import bipr_pkg::*;

  localparam int ROW_LIMIT = (MAX_ROWS < HEIGHT_CAP) ? MAX_ROWS : HEIGHT_CAP;

  logic                  in_vld_r;
  logic                  in_vld_nxt;
  logic [ROW_PIXELS-1:0] in_row_r;
  logic [ROW_PIXELS-1:0] older_r;
  logic [ROW_PIXELS-1:0] older_nxt;
  logic [ROW_PIXELS-1:0] newer_r;
  logic [ROW_PIXELS-1:0] newer_nxt;
  logic [NUM_W-1:0]      rows_r;
  logic [NUM_W-1:0]      rows_nxt;

  logic [ROW_PIXELS-1:0] mask;
  logic [ROW_PIXELS-1:0] cur;
  logic [ROW_PIXELS-1:0] above_last;
  logic [ROW_PIXELS-1:0] filt0;
  logic [ROW_PIXELS-1:0] filt1;
  logic [HEIGHT_W-1:0]   h_lim;
  logic                  has_prev;
  logic                  is_end;
  logic [1:0]            n;
  logic                  accept;
  logic                  consume;
  res_t                  res0;
  res_t                  res1;

  always_comb begin
    for (int i = 0; i < ROW_PIXELS; i++) begin
      mask[i] = (WIDTH_W'(i) < image_width);
    end
  end

  always_comb begin
    if (image_height > HEIGHT_W'(ROW_LIMIT)) begin
      h_lim = HEIGHT_W'(ROW_LIMIT);
    end else if (image_height == '0) begin
      h_lim = HEIGHT_W'(1);
    end else begin
      h_lim = image_height;
    end
  end

  assign cur        = in_row_r & mask;
  assign has_prev   = (rows_r != '0);
  assign is_end     = ({1'b0, rows_r} + HEIGHT_W'(1)) >= h_lim;
  assign above_last = has_prev ? newer_r : '0;

  bipr_filter #(.N(ROW_PIXELS)) u_filt_mid (
    .above (older_r),
    .mid   (newer_r),
    .below (cur),
    .mask  (mask),
    .filt  (filt0)
  );

  bipr_filter #(.N(ROW_PIXELS)) u_filt_last (
    .above (above_last),
    .mid   (cur),
    .below ('0),
    .mask  (mask),
    .filt  (filt1)
  );

  always_comb begin
    res0.row  = ROW_W'(filt0);
    res0.num  = rows_r - NUM_W'(1);
    res0.last = 1'b0;
    res1.row  = ROW_W'(filt1);
    res1.num  = rows_r;
    res1.last = 1'b1;
  end

  assign n       = {1'b0, has_prev} + {1'b0, is_end};
  assign consume = in_vld_r && (n <= free);
  assign in_stall = in_vld_r && !consume;
  assign accept  = in_valid && !in_stall;

  always_comb begin
    push.n = consume ? n : 2'd0;
    push.a = has_prev ? res0 : res1;
    push.b = res1;
  end

  assign in_vld_nxt = accept || (in_vld_r && !consume);

  always_comb begin
    older_nxt = older_r;
    newer_nxt = newer_r;
    rows_nxt  = rows_r;
    if (consume) begin
      if (is_end) begin
        older_nxt = '0;
        newer_nxt = '0;
        rows_nxt  = '0;
      end else begin
        older_nxt = above_last;
        newer_nxt = cur;
        rows_nxt  = rows_r + NUM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      older_r  <= '0;
      newer_r  <= '0;
      rows_r   <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      older_r  <= older_nxt;
      newer_r  <= newer_nxt;
      rows_r   <= rows_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_row_r <= in_row_pixels[ROW_PIXELS-1:0];
    end
  end

endmodule

@@ hw/rtl/bipr_out_q.sv @@
// bipr_out_q: two-entry result queue that drives the output channel
module bipr_out_q (
  input  logic            clk,
  input  logic            rst_n,
  input  bipr_pkg::push_t push,
  output logic [1:0]      free,
  output logic            out_valid,
  input  logic            out_stall,
  output bipr_pkg::res_t  head
);
  import bipr_pkg::*;

  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  res_t       q0_r;
  res_t       q0_nxt;
  res_t       q1_r;
  res_t       q1_nxt;
  logic       pop;
  logic [1:0] rc;
  res_t       e0;

  assign pop       = (cnt_r != 2'd0) && !out_stall;
  assign rc        = cnt_r - {1'b0, pop};
  assign e0        = pop ? q1_r : q0_r;
  assign free      = 2'd2 - rc;
  assign cnt_nxt   = rc + push.n;
  assign out_valid = (cnt_r != 2'd0);
  assign head      = q0_r;

  always_comb begin
    case (rc)
      2'd0: begin
        q0_nxt = push.a;
        q1_nxt = push.b;
      end
      2'd1: begin
        q0_nxt = e0;
        q1_nxt = push.a;
      end
      default: begin
        q0_nxt = q0_r;
        q1_nxt = q1_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule

@@ hw/rtl/binary_isolated_pixel_removal.sv @@
// binary_isolated_pixel_removal: top level, configuration registers and datapath
// One binary image row enters per item, top row first, and the block clears every set pixel
// whose eight neighbours are all clear (outside the image counts as clear). Each row after the
// first of a frame yields the filtered row above it; the last row of a frame also yields itself
// with out_frame_end set, so that item gives two results unless it is also the first row. Rows
// are accepted at one per cycle while in_stall is low; each is registered, and its results
// pass through the two-entry result queue; the input is held while the queue lacks room.
// The user must write image_width and image_height only while the block is idle; the block
// does not enforce it. Bits at or above the width are ignored on input and zero on output.
module binary_isolated_pixel_removal #(
  parameter int ROW_PIXELS = 64,
  parameter int MAX_ROWS   = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bipr_pkg::ROW_W-1:0]          in_row_pixels,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bipr_pkg::ROW_W-1:0]          out_filtered_row,
  output logic [bipr_pkg::NUM_W-1:0]          out_row_number,
  output logic                                out_frame_end,
  input  logic                                cfg_write_en,
  input  logic [bipr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bipr_pkg::HEIGHT_W-1:0]       cfg_wdata
);
  import bipr_pkg::*;

  logic [WIDTH_W-1:0]  image_width_r;
  logic [WIDTH_W-1:0]  image_width_nxt;
  logic [HEIGHT_W-1:0] image_height_r;
  logic [HEIGHT_W-1:0] image_height_nxt;
  logic [1:0]          free;
  push_t               push;
  res_t                head;

  always_comb begin
    image_width_nxt  = image_width_r;
    image_height_nxt = image_height_r;
    if (cfg_write_en) begin
      case (cfg_index)
        CFG_IDX_IMAGE_WIDTH:  image_width_nxt  = cfg_wdata[WIDTH_W-1:0];
        CFG_IDX_IMAGE_HEIGHT: image_height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RESET;
      image_height_r <= HEIGHT_RESET;
    end else begin
      image_width_r  <= image_width_nxt;
      image_height_r <= image_height_nxt;
    end
  end

  bipr_core #(
    .ROW_PIXELS (ROW_PIXELS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_row_pixels (in_row_pixels),
    .in_stall      (in_stall),
    .image_width   (image_width_r),
    .image_height  (image_height_r),
    .free          (free),
    .push          (push)
  );

  bipr_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_filtered_row = head.row;
  assign out_row_number   = head.num;
  assign out_frame_end    = head.last;

endmodule

@@ hw/rtl/bipr_checker.sv @@
// bipr_checker: port-level assertions for the top level and their bind
module bipr_checker #(
  parameter int ROW_PIXELS = 64
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [bipr_pkg::ROW_W-1:0]   out_filtered_row,
  input logic [bipr_pkg::NUM_W-1:0]   out_row_number,
  input logic                         out_frame_end
);
  import bipr_pkg::*;

  logic [NUM_W-1:0] exp_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_num_r <= '0;
    end else if (out_valid && !out_stall) begin
      exp_num_r <= out_frame_end ? '0 : out_row_number + NUM_W'(1);
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_filtered_row)
      && $stable(out_row_number) && $stable(out_frame_end))
    else $error("stalled item changed");

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_row_number == exp_num_r)
    else $error("row number out of sequence");

  a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_filtered_row >> ROW_PIXELS) == '0)
    else $error("pixels beyond row length set");

endmodule

bind binary_isolated_pixel_removal bipr_checker #(.ROW_PIXELS(ROW_PIXELS)) u_bipr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_filtered_row (out_filtered_row),
  .out_row_number   (out_row_number),
  .out_frame_end    (out_frame_end)
);

@@ tb/sv/tb_binary_isolated_pixel_removal.sv @@
// tb_binary_isolated_pixel_removal: self-checking testbench for the isolated pixel removal block
`timescale 1ns / 100ps

module tb_binary_isolated_pixel_removal;
  import bipr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 50;

  typedef enum logic [1:0] {STEP_ROW, STEP_WIDTH, STEP_HEIGHT} step_kind_t;

  typedef struct {
    step_kind_t       kind;
    logic [ROW_W-1:0] value;
    bit               typed;
    logic [ROW_W-1:0] want_row;
  } dir_step_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ROW_W-1:0]     in_row_pixels = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ROW_W-1:0]     out_filtered_row;
  logic [NUM_W-1:0]     out_row_number;
  logic                 out_frame_end;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [HEIGHT_W-1:0]  cfg_wdata = '0;

  // predictor state and configuration
  logic [ROW_W-1:0]    prev2_row;
  logic [ROW_W-1:0]    prev_row;
  logic [NUM_W-1:0]    row_idx;
  logic [WIDTH_W-1:0]  cur_width;
  logic [HEIGHT_W-1:0] cur_height;

  res_t      expected_rows[$];
  res_t      head;
  dir_step_t dir_steps[$];
  int        mismatches = 0;
  int        cycle_count = 0;
  bit        send_gaps = 1'b1;
  bit        drain_gaps = 1'b1;
  int        hold_asks = 0;
  int        holds_done = 0;
  int        stall_left = 0;

  binary_isolated_pixel_removal u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_row_pixels    (in_row_pixels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_filtered_row (out_filtered_row),
    .out_row_number   (out_row_number),
    .out_frame_end    (out_frame_end),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [ROW_W-1:0] width_mask(logic [WIDTH_W-1:0] w);
    if (w >= ROW_W) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic logic [ROW_W-1:0] clear_isolated(logic [ROW_W-1:0] above,
                                                      logic [ROW_W-1:0] mid,
                                                      logic [ROW_W-1:0] below,
                                                      logic [ROW_W-1:0] mask);
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] m;
    logic [ROW_W-1:0] b;
    logic [ROW_W-1:0] near;
    a = above & mask;
    m = mid & mask;
    b = below & mask;
    near = a | (a << 1) | (a >> 1) | b | (b << 1) | (b >> 1) | (m << 1) | (m >> 1);
    return m & near & mask;
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    logic [ROW_W-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: return a;
      1: return a & b & c;
      2: return a & b;
      3: return 64'd1 << $urandom_range(0, ROW_W - 1);
      default: return ($urandom_range(0, 1) != 0) ? '1 : '0;
    endcase
  endfunction

  // advance the frame by one accepted row and queue what it yields, or the given typed result
  task automatic predict_row(logic [ROW_W-1:0] pix, bit typed, logic [ROW_W-1:0] want_row);
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] cur;
    logic [ROW_W-1:0] above;
    int               h;
    int               r;
    res_t             got[$];
    mask = width_mask(cur_width);
    h = (cur_height > HEIGHT_CAP) ? HEIGHT_CAP : int'(cur_height);
    if (h < 1) h = 1;
    cur = pix & mask;
    r = row_idx;
    if (r > 0) begin
      got.push_back('{row: clear_isolated(prev2_row, prev_row, cur, mask),
                      num: NUM_W'(r - 1), last: 1'b0});
    end
    if (r + 1 >= h) begin
      above = (r > 0) ? prev_row : '0;
      got.push_back('{row: clear_isolated(above, cur, '0, mask), num: NUM_W'(r), last: 1'b1});
      prev2_row = '0;
      prev_row = '0;
      row_idx = '0;
    end else begin
      prev2_row = (r > 0) ? prev_row : '0;
      prev_row = cur;
      row_idx = NUM_W'(r + 1);
    end
    if (typed) begin
      expected_rows.push_back('{row: want_row, num: '0, last: 1'b1});
    end else begin
      foreach (got[i]) expected_rows.push_back(got[i]);
    end
  endtask

  task automatic send_row(logic [ROW_W-1:0] pix, bit typed, logic [ROW_W-1:0] want_row);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_row_pixels <= pix;
    do @(posedge clk); while (in_stall);
    predict_row(pix, typed, want_row);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [HEIGHT_W-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == CFG_IDX_IMAGE_WIDTH) cur_width = value[WIDTH_W-1:0];
    else cur_height = value;
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(logic [HEIGHT_W-1:0] w, logic [HEIGHT_W-1:0] h, int n);
    wait_drained();
    write_reg(CFG_IDX_IMAGE_WIDTH, w);
    write_reg(CFG_IDX_IMAGE_HEIGHT, h);
    repeat (n) send_row(rand_row(), 1'b0, '0);
  endtask

  // result receiver: random stall bursts plus requested long holds
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (holds_done != hold_asks) begin
      holds_done++;
      stall_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (drain_gaps && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected item row %h num %0d end %b", $time,
                 out_filtered_row, out_row_number, out_frame_end);
        mismatches++;
      end else begin
        head = expected_rows.pop_front();
        if (out_filtered_row !== head.row) begin
          $display("%0t: filtered_row expected %h got %h", $time, head.row, out_filtered_row);
          mismatches++;
        end
        if (out_row_number !== head.num) begin
          $display("%0t: row_number expected %0d got %0d", $time, head.num, out_row_number);
          mismatches++;
        end
        if (out_frame_end !== head.last) begin
          $display("%0t: frame_end expected %b got %b", $time, head.last, out_frame_end);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_binary_isolated_pixel_removal: errors");
      $finish;
    end
  end

  initial begin
    prev2_row = '0;
    prev_row = '0;
    row_idx = '0;
    cur_width = WIDTH_RESET;
    cur_height = HEIGHT_RESET;

    dir_steps.push_back('{STEP_ROW, '1, 1'b0, '0});
    dir_steps.push_back('{STEP_ROW, 64'h1, 1'b0, '0});
    dir_steps.push_back('{STEP_HEIGHT, 64'd1, 1'b0, '0});
    dir_steps.push_back('{STEP_ROW, '1, 1'b1, '1});
    dir_steps.push_back('{STEP_ROW, 64'h1, 1'b1, '0});
    dir_steps.push_back('{STEP_ROW, 64'h8000_0000_0000_0000, 1'b1, '0});
    dir_steps.push_back('{STEP_ROW, 64'h3, 1'b1, 64'h3});
    dir_steps.push_back('{STEP_ROW, 64'hC000_0000_0000_0000, 1'b1, 64'hC000_0000_0000_0000});
    dir_steps.push_back('{STEP_WIDTH, 64'd0, 1'b0, '0});
    dir_steps.push_back('{STEP_ROW, '1, 1'b1, '0});
    dir_steps.push_back('{STEP_WIDTH, 64'd1, 1'b0, '0});
    dir_steps.push_back('{STEP_ROW, '1, 1'b1, '0});
    dir_steps.push_back('{STEP_WIDTH, 64'd127, 1'b0, '0});
    dir_steps.push_back('{STEP_HEIGHT, 64'd0, 1'b0, '0});
    dir_steps.push_back('{STEP_ROW, 64'h5, 1'b1, '0});
    dir_steps.push_back('{STEP_ROW, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '0});
    dir_steps.push_back('{STEP_ROW, 64'h5555_5555_5555_5555, 1'b1, '0});
    dir_steps.push_back('{STEP_HEIGHT, 64'd3, 1'b0, '0});
    dir_steps.push_back('{STEP_WIDTH, 64'd5, 1'b0, '0});
    dir_steps.push_back('{STEP_ROW, '1, 1'b0, '0});
    dir_steps.push_back('{STEP_ROW, 64'hFFFF_FFFF_FFFF_FFE0, 1'b0, '0});
    dir_steps.push_back('{STEP_ROW, 64'h0, 1'b0, '0});
    dir_steps.push_back('{STEP_HEIGHT, 64'd8191, 1'b0, '0});
    dir_steps.push_back('{STEP_ROW, 64'h0F0, 1'b0, '0});
    dir_steps.push_back('{STEP_WIDTH, 64'd64, 1'b0, '0});
    dir_steps.push_back('{STEP_ROW, '1, 1'b0, '0});
    dir_steps.push_back('{STEP_ROW, 64'h1, 1'b0, '0});
    dir_steps.push_back('{STEP_HEIGHT, 64'd2, 1'b0, '0});
    dir_steps.push_back('{STEP_ROW, 64'h2, 1'b0, '0});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_steps[i]) begin
      case (dir_steps[i].kind)
        STEP_ROW: begin
          send_row(dir_steps[i].value, dir_steps[i].typed, dir_steps[i].want_row);
        end
        STEP_WIDTH: begin
          wait_drained();
          write_reg(CFG_IDX_IMAGE_WIDTH, dir_steps[i].value[HEIGHT_W-1:0]);
        end
        default: begin
          wait_drained();
          write_reg(CFG_IDX_IMAGE_HEIGHT, dir_steps[i].value[HEIGHT_W-1:0]);
        end
      endcase
    end

    run_phase(64, 2, 40);
    run_phase(2, 3, 30);
    run_phase(17, 5, 40);
    run_phase(1, 4, 20);
    run_phase(0, 3, 20);
    run_phase(100, 0, 20);
    // height beyond the cap, frame cut short by the next height
    run_phase(64, 8191, 60);

    // long receiver hold so the block fills and stalls its input
    wait_drained();
    hold_asks++;
    run_phase(33, 7, 120);

    repeat (4) run_phase(HEIGHT_W'($urandom_range(0, 127)), HEIGHT_W'($urandom_range(0, 12)), 40);

    // no idling in the last part; sender pauses halfway until drained
    send_gaps = 1'b0;
    drain_gaps = 1'b0;
    run_phase(64, 6, 50);
    wait_drained();
    repeat (50) send_row(rand_row(), 1'b0, '0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (expected_rows.size() != 0) begin
      $display("%0t: %0d expected items never arrived", $time, expected_rows.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_binary_isolated_pixel_removal: clean");
    end else begin
      $display("tb_binary_isolated_pixel_removal: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/bipr_pkg.sv
hw/rtl/bipr_filter.sv
hw/rtl/bipr_core.sv
hw/rtl/bipr_out_q.sv
hw/rtl/binary_isolated_pixel_removal.sv
hw/rtl/bipr_checker.sv
tb/sv/tb_binary_isolated_pixel_removal.sv
